/* sv/nvl_pkg.sv */
// ----------------------------------------------------------------------------
// nvl_pkg
// Types, codes and resolution tables shared by the nine-valued logic unit.
// ----------------------------------------------------------------------------
package nvl_pkg;

    // Element codes: U, X, 0, 1, Z, W, L, H, don't care.
    localparam logic [3:0] NV_U  = 4'h0;
    localparam logic [3:0] NV_X  = 4'h1;
    localparam logic [3:0] NV_0  = 4'h2;
    localparam logic [3:0] NV_1  = 4'h3;
    localparam logic [3:0] NV_Z  = 4'h4;
    localparam logic [3:0] NV_W  = 4'h5;
    localparam logic [3:0] NV_L  = 4'h6;
    localparam logic [3:0] NV_H  = 4'h7;
    localparam logic [3:0] NV_DC = 4'h8;

    typedef enum logic [2:0] {
        KIND_AND = 3'd0,
        KIND_OR  = 3'd1,
        KIND_XOR = 3'd2,
        KIND_ADD = 3'd3,
        KIND_X01 = 3'd4
    } nvl_kind_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] left_elem;
        logic [3:0] right_elem;
        logic [3:0] carry_in;
        logic       first;
        logic       last;
    } nvl_in_t;

    typedef struct packed {
        logic [3:0] result_elem;
        logic       result_last;
    } nvl_out_t;

    localparam logic [3:0] AND_TAB [9][9] = '{
        '{NV_U, NV_U, NV_0, NV_U, NV_U, NV_U, NV_0, NV_U, NV_U},
        '{NV_U, NV_X, NV_0, NV_X, NV_X, NV_X, NV_0, NV_X, NV_X},
        '{NV_0, NV_0, NV_0, NV_0, NV_0, NV_0, NV_0, NV_0, NV_0},
        '{NV_U, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X},
        '{NV_U, NV_X, NV_0, NV_X, NV_X, NV_X, NV_0, NV_X, NV_X},
        '{NV_U, NV_X, NV_0, NV_X, NV_X, NV_X, NV_0, NV_X, NV_X},
        '{NV_0, NV_0, NV_0, NV_0, NV_0, NV_0, NV_0, NV_0, NV_0},
        '{NV_U, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X},
        '{NV_U, NV_X, NV_0, NV_X, NV_X, NV_X, NV_0, NV_X, NV_X}
    };

    localparam logic [3:0] OR_TAB [9][9] = '{
        '{NV_U, NV_U, NV_U, NV_1, NV_U, NV_U, NV_U, NV_1, NV_U},
        '{NV_U, NV_X, NV_X, NV_1, NV_X, NV_X, NV_X, NV_1, NV_X},
        '{NV_U, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X},
        '{NV_1, NV_1, NV_1, NV_1, NV_1, NV_1, NV_1, NV_1, NV_1},
        '{NV_U, NV_X, NV_X, NV_1, NV_X, NV_X, NV_X, NV_1, NV_X},
        '{NV_U, NV_X, NV_X, NV_1, NV_X, NV_X, NV_X, NV_1, NV_X},
        '{NV_U, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X},
        '{NV_1, NV_1, NV_1, NV_1, NV_1, NV_1, NV_1, NV_1, NV_1},
        '{NV_U, NV_X, NV_X, NV_1, NV_X, NV_X, NV_X, NV_1, NV_X}
    };

    localparam logic [3:0] XOR_TAB [9][9] = '{
        '{NV_U, NV_U, NV_U, NV_U, NV_U, NV_U, NV_U, NV_U, NV_U},
        '{NV_U, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X},
        '{NV_U, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X},
        '{NV_U, NV_X, NV_1, NV_0, NV_X, NV_X, NV_1, NV_0, NV_X},
        '{NV_U, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X},
        '{NV_U, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X},
        '{NV_U, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X},
        '{NV_U, NV_X, NV_1, NV_0, NV_X, NV_X, NV_1, NV_0, NV_X},
        '{NV_U, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X, NV_X}
    };

    localparam logic [3:0] X01_TAB [9] = '{
        NV_X, NV_X, NV_0, NV_1, NV_X, NV_X, NV_0, NV_1, NV_X
    };

    // Codes above don't care carry no meaning and are read as X.
    function automatic logic [3:0] nv_norm(input logic [3:0] v);
        return (v > NV_DC) ? NV_X : v;
    endfunction

    // The table functions expect normalized operands.
    function automatic logic [3:0] nv_and(input logic [3:0] a, input logic [3:0] b);
        return AND_TAB[a][b];
    endfunction

    function automatic logic [3:0] nv_or(input logic [3:0] a, input logic [3:0] b);
        return OR_TAB[a][b];
    endfunction

    function automatic logic [3:0] nv_xor(input logic [3:0] a, input logic [3:0] b);
        return XOR_TAB[a][b];
    endfunction

    function automatic logic [3:0] nv_x01(input logic [3:0] a);
        return X01_TAB[a];
    endfunction

endpackage

/* sv/nvl_in_reg.sv */
// ----------------------------------------------------------------------------
// nvl_in_reg
// Input register: holds one accepted item until the execute stage takes it.
// ----------------------------------------------------------------------------
module nvl_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  nvl_pkg::nvl_in_t s_data,
    input  logic           take,
    output logic           hold_valid,
    output nvl_pkg::nvl_in_t hold_data
);
    import nvl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    nvl_in_t data_reg;
    logic    load;

    // The register is free when empty or when its item leaves this cycle.
    assign s_ready = !valid_reg || take;
    assign load    = s_valid && s_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

/* sv/nvl_exec.sv */
// ----------------------------------------------------------------------------
// nvl_exec
// Table lookups for one element pair and the running add carry.
// ----------------------------------------------------------------------------
module nvl_exec (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  nvl_pkg::nvl_in_t op_data,
    output nvl_pkg::nvl_out_t res_data
);
    import nvl_pkg::*;

    logic [3:0] carry_reg;
    logic [3:0] carry_next;
    logic [3:0] l_norm;
    logic [3:0] r_norm;
    logic [3:0] c_use;
    logic [3:0] add_sum;
    logic [3:0] add_carry;
    logic [3:0] res_elem;
    logic       is_add;

    assign l_norm = nv_norm(op_data.left_elem);
    assign r_norm = nv_norm(op_data.right_elem);

    // The first element of a vector starts from the supplied carry.
    assign c_use = op_data.first ? nv_norm(op_data.carry_in) : carry_reg;

    assign add_sum   = nv_xor(nv_xor(c_use, l_norm), r_norm);
    assign add_carry = nv_or(nv_or(nv_and(c_use, l_norm), nv_and(c_use, r_norm)),
                             nv_and(l_norm, r_norm));

    assign is_add = (op_data.kind == KIND_ADD);

    always_comb begin
        unique case (op_data.kind)
            KIND_AND: res_elem = nv_and(l_norm, r_norm);
            KIND_OR:  res_elem = nv_or(l_norm, r_norm);
            KIND_XOR: res_elem = nv_xor(l_norm, r_norm);
            KIND_ADD: res_elem = add_sum;
            KIND_X01: res_elem = nv_x01(l_norm);
            default:  res_elem = NV_U;
        endcase
    end

    assign carry_next = (fire && is_add) ? add_carry : carry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= NV_U;
        end else begin
            carry_reg <= carry_next;
        end
    end

    assign res_data.result_elem = res_elem;
    assign res_data.result_last = op_data.last;

endmodule

/* sv/nine_valued_logic_element_unit_core.sv */
// ----------------------------------------------------------------------------
// nine_valued_logic_element_unit_core
// Element-wise std_logic and, or, xor, ripple add and X01 conversion.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                      | Carries
//   --------+----------------------------+----------------------------------
//   input   | s_valid, s_ready, s_data   | one element pair, op kind, marks
//   result  | m_valid, m_ready, m_data   | one result element, last mark
//
// Every transfer on the input channel produces exactly one result transfer.
// An item is held in the input register and is then looked up and written
// to the result register, from which its result transfer is offered. One
// item per cycle is sustained while m_ready stays high, set by the single
// pass through the lookup tables and the carry register feedback.
// Reset (aresetn low at a clock edge) empties both registers and sets the
// add carry to U. A stall on the result side holds the result register and
// then the input register; the input stays open while the input register
// is empty even if a result is waiting.
// ----------------------------------------------------------------------------
module nine_valued_logic_element_unit_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nvl_pkg::nvl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nvl_pkg::nvl_out_t m_data
);
    import nvl_pkg::*;

    logic     op_valid;
    nvl_in_t  op_data;
    nvl_out_t res_data;
    logic     advance;
    logic     m_valid_reg;
    logic     m_valid_next;
    nvl_out_t m_data_reg;

    // An item moves to the result register when there is one waiting and the
    // result register is empty or being drained in this cycle.
    assign advance = op_valid && (!m_valid_reg || m_ready);

    nvl_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (advance),
        .hold_valid (op_valid),
        .hold_data  (op_data)
    );

    // The carry is updated only when an add item actually moves on, so a
    // stalled add item keeps seeing the carry from the element before it.
    nvl_exec u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (advance),
        .op_data  (op_data),
        .res_data (res_data)
    );

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is captured only with a new item and otherwise held.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* test/tb_nine_valued_logic_element_unit_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nine_valued_logic_element_unit_core
// Self-checking bench for the element-wise std_logic unit. Element pairs go
// in over a valid/ready channel with random gaps, results are checked one by
// one against an independent prediction of and, or, xor, X01 and ripple add.
// ----------------------------------------------------------------------------
module tb_nine_valued_logic_element_unit_core;

    import nvl_pkg::*;

    // Kinds that the unit leaves unused; they must give U and keep the carry.
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    // Highest code that fits the element field; anything above don't care is X.
    localparam logic [3:0] CODE_TOP      = 4'hF;

    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PCT       = 19;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MIXED_ITEMS    = 620;
    localparam int BURST_ITEMS    = 230;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    nvl_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    nvl_out_t m_data;

    // Predicted state of the unit: only the nine-valued add carry.
    logic [3:0] model_carry = NV_U;
    // Results still owed by the unit, oldest first.
    nvl_out_t   pending_results[$];

    int  error_count   = 0;
    int  accepted_ins  = 0;
    int  checked_outs  = 0;
    int  add_vectors   = 0;
    int  quiet_cycles  = 0;
    // While set, neither side idles: one long stretch at full rate.
    bit  calm          = 1'b0;

    nine_valued_logic_element_unit_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    // Every std_logic value behaves, for these operations, like one of four
    // strengths: U stays U, L and 0 act as 0, H and 1 act as 1, and X, Z, W,
    // don't care and every out-of-range code act as X. The tables collapse to
    // a few precedence rules over those four classes.
    function automatic logic [3:0] strength_of(input logic [3:0] code);
        case (code)
            NV_U:       return NV_U;
            NV_0, NV_L: return NV_0;
            NV_1, NV_H: return NV_1;
            default:    return NV_X;
        endcase
    endfunction

    // For and, a 0 on either side wins even over U.
    function automatic logic [3:0] and_elem(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] fa;
        logic [3:0] fb;
        fa = strength_of(a);
        fb = strength_of(b);
        if (fa == NV_0 || fb == NV_0) return NV_0;
        if (fa == NV_U || fb == NV_U) return NV_U;
        if (fa == NV_X || fb == NV_X) return NV_X;
        return NV_1;
    endfunction

    // For or, a 1 on either side wins even over U.
    function automatic logic [3:0] or_elem(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] fa;
        logic [3:0] fb;
        fa = strength_of(a);
        fb = strength_of(b);
        if (fa == NV_1 || fb == NV_1) return NV_1;
        if (fa == NV_U || fb == NV_U) return NV_U;
        if (fa == NV_X || fb == NV_X) return NV_X;
        return NV_0;
    endfunction

    // For xor, nothing dominates: U beats X, and only two strong values
    // give a strong result.
    function automatic logic [3:0] xor_elem(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] fa;
        logic [3:0] fb;
        fa = strength_of(a);
        fb = strength_of(b);
        if (fa == NV_U || fb == NV_U) return NV_U;
        if (fa == NV_X || fb == NV_X) return NV_X;
        return (fa == fb) ? NV_0 : NV_1;
    endfunction

    // Works out the result of one element and advances the predicted carry.
    function automatic nvl_out_t predict_element(input nvl_in_t item);
        nvl_out_t   outcome;
        logic [3:0] cin;
        logic [3:0] lhs;
        logic [3:0] rhs;
        lhs = item.left_elem;
        rhs = item.right_elem;
        outcome.result_last = item.last;
        outcome.result_elem = NV_U;
        case (item.kind)
            KIND_AND: outcome.result_elem = and_elem(lhs, rhs);
            KIND_OR:  outcome.result_elem = or_elem(lhs, rhs);
            KIND_XOR: outcome.result_elem = xor_elem(lhs, rhs);
            KIND_ADD: begin
                // A first mark restarts the chain from carry_in.
                cin = item.first ? item.carry_in : model_carry;
                outcome.result_elem = xor_elem(xor_elem(cin, lhs), rhs);
                model_carry = or_elem(or_elem(and_elem(cin, lhs), and_elem(cin, rhs)),
                                      and_elem(lhs, rhs));
            end
            KIND_X01: begin
                // X01 only differs from the strength class in mapping U to X.
                outcome.result_elem = strength_of(lhs);
                if (outcome.result_elem == NV_U) outcome.result_elem = NV_X;
            end
            default: outcome.result_elem = NV_U;
        endcase
        return outcome;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard and watchdog
    // ------------------------------------------------------------------------
    // Everything is sampled at the rising edge. The bench only moves its
    // inputs at the falling edge and the unit's outputs settle after its own
    // edge updates, so the values read here are the ones the edge acted on.
    always @(posedge aclk) begin : scoreboard
        nvl_out_t owed;
        bit       moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                moved = 1'b1;
                checked_outs++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: result_elem %0d result_last %0d",
                           m_data.result_elem, m_data.result_last);
                    error_count++;
                end else begin
                    owed = pending_results.pop_front();
                    if (m_data.result_elem !== owed.result_elem) begin
                        $error("result_elem mismatch: expected %0d, actual %0d",
                               owed.result_elem, m_data.result_elem);
                        error_count++;
                    end
                    if (m_data.result_last !== owed.result_last) begin
                        $error("result_last mismatch: expected %0d, actual %0d",
                               owed.result_last, m_data.result_last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                accepted_ins++;
                pending_results.push_back(predict_element(s_data));
            end
            // A stuck handshake on either side shows up as a long run of
            // cycles in which no transfer happens at all.
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // The result side stalls at random unless a calm stretch is running.
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic nvl_in_t make_item(input logic [2:0] kind, input logic [3:0] lhs,
                                          input logic [3:0] rhs, input logic [3:0] cin,
                                          input logic first, input logic last);
        nvl_in_t item;
        item.kind       = kind;
        item.left_elem  = lhs;
        item.right_elem = rhs;
        item.carry_in   = cin;
        item.first      = first;
        item.last       = last;
        return item;
    endfunction

    // Mostly legal codes, with a share of the out-of-range ones that read as X.
    function automatic logic [3:0] random_code();
        if ($urandom_range(99) < 85) return 4'($urandom_range(8));
        return 4'($urandom_range(15, 9));
    endfunction

    function automatic nvl_in_t random_item();
        return make_item(3'($urandom_range(7)), 4'($urandom_range(15)),
                         4'($urandom_range(15)), 4'($urandom_range(15)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Offers one item and returns at the falling edge after its transfer.
    // Valid stays high on return, so back-to-back items need no extra step.
    task automatic send_element(input nvl_in_t item);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Holds the input side off until every owed result has been checked.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // The carry comes out of reset as U, so an add without a first mark
    // right after reset must chain from U.
    task automatic test_reset_carry();
        send_element(make_item(KIND_ADD, NV_H, NV_H, NV_X, 1'b0, 1'b0));
        send_element(make_item(KIND_ADD, NV_0, NV_0, NV_1, 1'b0, 1'b1));
    endtask

    // Code extremes for each table operation, including out-of-range codes.
    task automatic test_element_extremes();
        send_element(make_item(KIND_AND, NV_U, NV_DC, NV_U, 1'b0, 1'b1));
        send_element(make_item(KIND_AND, CODE_TOP, NV_1, CODE_TOP, 1'b1, 1'b0));
        send_element(make_item(KIND_AND, NV_L, NV_H, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_OR, NV_1, CODE_TOP, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_OR, NV_DC, NV_0, NV_U, 1'b1, 1'b1));
        send_element(make_item(KIND_OR, NV_U, NV_H, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_XOR, NV_H, NV_H, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_XOR, CODE_TOP, CODE_TOP, CODE_TOP, 1'b1, 1'b1));
        send_element(make_item(KIND_XOR, NV_U, NV_1, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_XOR, NV_L, NV_1, NV_U, 1'b0, 1'b1));
        send_element(make_item(KIND_X01, NV_U, NV_1, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_X01, NV_L, NV_U, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_X01, NV_H, NV_U, NV_U, 1'b0, 1'b0));
        send_element(make_item(KIND_X01, NV_DC, NV_DC, NV_U, 1'b0, 1'b1));
        send_element(make_item(KIND_X01, CODE_TOP, CODE_TOP, CODE_TOP, 1'b1, 1'b1));
    endtask

    // First marks on add, an out-of-range carry_in, and the carry surviving
    // other kinds, including the unused ones, that carry first marks.
    task automatic test_add_marks();
        send_element(make_item(KIND_ADD, NV_0, CODE_TOP, CODE_TOP, 1'b1, 1'b0));
        send_element(make_item(KIND_ADD, NV_1, NV_1, NV_1, 1'b1, 1'b0));
        send_element(make_item(KIND_AND, NV_1, NV_0, NV_0, 1'b1, 1'b0));
        send_element(make_item(KIND_SPARE_LO, NV_1, NV_1, NV_0, 1'b1, 1'b1));
        send_element(make_item(KIND_SPARE_HI, CODE_TOP, CODE_TOP, CODE_TOP, 1'b1, 1'b1));
        send_element(make_item(KIND_ADD, NV_0, NV_0, NV_0, 1'b0, 1'b1));
    endtask

    // Mostly well-formed add vectors with random content, some of them with
    // other operations slipped in between elements; the rest is broken
    // chains and fully random items of any kind.
    task automatic test_random_traffic(input int item_total);
        int         sent;
        int         choice;
        int         span;
        logic [3:0] cin;
        sent = 0;
        while (sent < item_total) begin
            choice = $urandom_range(99);
            if (choice < 55) begin
                span = $urandom_range(8, 1);
                cin  = random_code();
                add_vectors++;
                for (int idx = 0; idx < span; idx++) begin
                    send_element(make_item(KIND_ADD, random_code(), random_code(),
                                           (idx == 0) ? cin : 4'($urandom_range(15)),
                                           idx == 0, idx == span - 1));
                    sent++;
                    if (idx < span - 1 && $urandom_range(99) < 20) begin
                        send_element(make_item(3'($urandom_range(7)), random_code(),
                                               random_code(), 4'($urandom_range(15)),
                                               1'($urandom_range(1)), 1'b0));
                        sent++;
                    end
                end
            end else if (choice < 70) begin
                span = $urandom_range(4, 1);
                for (int idx = 0; idx < span; idx++) begin
                    send_element(make_item(KIND_ADD, random_code(), random_code(),
                                           4'($urandom_range(15)), 1'($urandom_range(1)),
                                           1'($urandom_range(1))));
                    sent++;
                end
            end else begin
                send_element(random_item());
                sent++;
            end
        end
    endtask

    // The sender stops and lets the unit empty out completely before going on.
    task automatic test_idle_drain();
        wait_for_results();
        send_element(random_item());
    endtask

    // A long run with neither side idling, so the unit works at full rate.
    task automatic test_calm_burst(input int item_total);
        calm = 1'b1;
        test_random_traffic(item_total);
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_carry();
        test_element_extremes();
        test_add_marks();
        test_random_traffic(MIXED_ITEMS / 2);
        test_idle_drain();
        test_calm_burst(BURST_ITEMS);
        test_random_traffic(MIXED_ITEMS / 2);

        // Let everything owed come out, then keep clocking so that any stray
        // result the unit might still emit shows up.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        $display("Run covered %0d input transfers and %0d checked results,", accepted_ins,
                 checked_outs);
        $display("with %0d add chains, all kinds including unused ones, and %0d errors.",
                 add_vectors, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/nvl_pkg.sv
sv/nvl_in_reg.sv
sv/nvl_exec.sv
sv/nine_valued_logic_element_unit_core.sv
test/tb_nine_valued_logic_element_unit_core.sv
